### rtl/graph_traversal_engine_defines.svh
// Assertion helpers shared by the graph traversal engine RTL.
`ifndef GRAPH_TRAVERSAL_ENGINE_DEFINES_SVH
`define GRAPH_TRAVERSAL_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GTE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("graph traversal engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GTE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("graph traversal engine: next-cycle check failed");

`endif

### rtl/gte_pkg.sv
package gte_pkg;

    // Field widths of the stream payloads.
    localparam int VW       = 6;
    localparam int EDGE_W   = 32;
    localparam int IDX_W    = 5;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 8;

    // Default size of the vertex store.
    localparam int DEF_MAX_VERTICES = 32;

    // Operation codes carried in s_tuser.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Configuration register indexes and widths.
    localparam int   CFG_AW    = 1;
    localparam int   CFG_DW    = 6;
    localparam logic [CFG_AW-1:0] REG_MODE  = 1'b0;
    localparam logic [CFG_AW-1:0] REG_COUNT = 1'b1;

    // Traversal modes.
    localparam logic MODE_BFS = 1'b0;
    localparam logic MODE_DFS = 1'b1;

    // Reset value of the vertex count register.
    localparam logic [VW-1:0] COUNT_RESET = 6'd32;

    // Result of the lowest-set-bit picker.
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [EDGE_W-1:0] onehot;
    } pick_t;

endpackage

### rtl/gte_pick.sv
module gte_pick (
    input  logic [gte_pkg::EDGE_W-1:0] cand,
    output gte_pkg::pick_t             pick
);

    logic [gte_pkg::EDGE_W-1:0] low_bit;
    logic [gte_pkg::IDX_W-1:0]  idx;

    // Isolate the lowest set bit, then encode its position.
    always_comb begin
        low_bit = cand & (~cand + gte_pkg::EDGE_W'(1));
        idx     = '0;
        for (int k = 0; k < gte_pkg::EDGE_W; k++) begin
            if (low_bit[k]) begin
                idx = idx | gte_pkg::IDX_W'(k);
            end
        end
        pick.found  = |cand;
        pick.idx    = idx;
        pick.onehot = low_bit;
    end

endmodule

### rtl/gte_adj_mem.sv
module gte_adj_mem #(
    parameter int MAX_VERTICES = gte_pkg::DEF_MAX_VERTICES
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   wr_en,
    input  logic [$clog2(MAX_VERTICES)-1:0]        wr_addr,
    input  logic [gte_pkg::EDGE_W-1:0]             wr_data,
    input  logic [$clog2(MAX_VERTICES)-1:0]        rd_addr,
    output logic [gte_pkg::EDGE_W-1:0]             rd_row
);

    logic [gte_pkg::EDGE_W-1:0] row_mem_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]    row_valid_reg;
    logic [gte_pkg::EDGE_W-1:0] rd_data_reg;
    logic                       rd_valid_reg;

    // Row storage with a registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= row_mem_reg[rd_addr];
    end

    // Per-row valid bits make every row read as zero after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

### rtl/graph_traversal_engine.sv
// Timing: a row load is written at its accepting edge; a bad start goes to the emit state,
// which registers its error result once the output can take it. Each visited vertex, the
// first included, passes the pop, fetch, row, scan and emit states; the scan finds its new
// neighbors one per cycle with the shared lowest-bit picker. Throughput: one item at a time.
// Reset (aresetn, synchronous, active low) clears all adjacency rows, visited marks,
// list pointers and the result register; mode becomes breadth-first, count 32.
`include "graph_traversal_engine_defines.svh"

module graph_traversal_engine #(
    parameter int MAX_VERTICES = gte_pkg::DEF_MAX_VERTICES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port.
    input  logic                           cfg_wr_en,
    input  logic [gte_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [gte_pkg::CFG_DW-1:0]     cfg_wdata,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: row_vertex[5:0], row_edges[37:6], start_vertex[43:38], zero pad[47:44]
    input  logic [gte_pkg::S_DATA_W-1:0]   s_tdata,
    // s_tuser: operation[0]
    input  logic                           s_tuser,
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: visited_vertex[5:0], zero pad[7:6]
    output logic [gte_pkg::M_DATA_W-1:0]   m_tdata,
    // m_tuser: bad_start[0]
    output logic                           m_tuser,
    output logic                           m_tlast
);

    localparam int VW   = gte_pkg::VW;
    localparam int EW   = gte_pkg::EDGE_W;
    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int MapW = (MAX_VERTICES < EW) ? MAX_VERTICES : EW;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_POP   = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_ROW   = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic                mode_reg;
    logic [VW-1:0]       count_reg;
    logic [MAX_VERTICES-1:0] vis_reg, vis_next;
    logic [CW-1:0]       head_reg, head_next;
    logic [CW-1:0]       tail_reg, tail_next;
    logic [VW-1:0]       cur_reg, cur_next;
    logic                bad_reg, bad_next;
    logic [EW-1:0]       cand_reg, cand_next;

    logic                out_valid_reg, out_valid_next;
    logic [VW-1:0]       out_vertex_reg, out_vertex_next;
    logic                out_last_reg, out_last_next;
    logic                out_bad_reg, out_bad_next;

    logic [VW-1:0]       wl_mem_reg [MAX_VERTICES];
    logic [VW-1:0]       wl_rd_reg;
    logic [AW-1:0]       wl_raddr;
    logic                wl_we;
    logic [AW-1:0]       wl_waddr;
    logic [VW-1:0]       wl_wdata;

    logic                adj_we;
    logic [AW-1:0]       adj_waddr;
    logic [AW-1:0]       adj_raddr;
    logic [EW-1:0]       adj_row;

    logic                in_op;
    logic [VW-1:0]       in_row_vertex;
    logic [EW-1:0]       in_row_edges;
    logic [VW-1:0]       in_start;
    logic                in_take;

    logic [VW:0]         n_eff;
    logic [EW-1:0]       n_mask;
    logic [EW-1:0]       vis_map;
    logic                list_empty;
    logic                out_load;
    gte_pkg::pick_t      pick;

    // Unpack the input transaction.
    assign in_op         = s_tuser;
    assign in_row_vertex = s_tdata[5:0];
    assign in_row_edges  = s_tdata[37:6];
    assign in_start      = s_tdata[43:38];
    assign s_tready      = (state_reg == ST_IDLE);
    assign in_take       = s_tvalid && s_tready;

    // Effective vertex count and the masks derived from it.
    always_comb begin
        n_eff = ({1'b0, count_reg} > (VW+1)'(MAX_VERTICES)) ? (VW+1)'(MAX_VERTICES)
                                                             : {1'b0, count_reg};
        n_mask  = '0;
        vis_map = '0;
        for (int j = 0; j < EW; j++) begin
            n_mask[j] = ((VW+1)'(j) < n_eff);
        end
        for (int k = 0; k < MapW; k++) begin
            vis_map[k] = vis_reg[k];
        end
    end

    assign list_empty = (head_reg == tail_reg);

    // Shared lowest-set-bit picker for neighbor scanning.
    gte_pick u_pick (
        .cand (cand_reg),
        .pick (pick)
    );

    // Adjacency store.
    gte_adj_mem #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_adj_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (adj_we),
        .wr_addr (adj_waddr),
        .wr_data (in_row_edges),
        .rd_addr (adj_raddr),
        .rd_row  (adj_row)
    );

    assign adj_we    = in_take && (in_op == gte_pkg::OP_LOAD) && (in_row_vertex != '0)
                       && ((VW+1)'(in_row_vertex) <= (VW+1)'(MAX_VERTICES));
    assign adj_waddr = AW'(in_row_vertex - VW'(1));
    assign adj_raddr = AW'(wl_rd_reg - VW'(1));

    // Work list memory with a registered read port.
    always_ff @(posedge aclk) begin
        if (wl_we) begin
            wl_mem_reg[wl_waddr] <= wl_wdata;
        end
        wl_rd_reg <= wl_mem_reg[wl_raddr];
    end

    assign out_load = !out_valid_reg || m_tready;

    // Sequencer next-state logic.
    always_comb begin
        state_next      = state_reg;
        vis_next        = vis_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cur_next        = cur_reg;
        bad_next        = bad_reg;
        cand_next       = cand_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_vertex_next = out_vertex_reg;
        out_last_next   = out_last_reg;
        out_bad_next    = out_bad_reg;
        wl_we           = 1'b0;
        wl_waddr        = '0;
        wl_wdata        = in_start;
        wl_raddr        = (mode_reg == gte_pkg::MODE_BFS) ? head_reg[AW-1:0]
                                                          : AW'(tail_reg - CW'(1));

        unique case (state_reg)
            ST_IDLE: begin
                if (in_take && (in_op == gte_pkg::OP_START)) begin
                    if ((in_start == '0) || ({1'b0, in_start} > n_eff)) begin
                        cur_next   = '0;
                        bad_next   = 1'b1;
                        state_next = ST_EMIT;
                    end else begin
                        for (int k = 0; k < MAX_VERTICES; k++) begin
                            vis_next[k] = ((in_start - VW'(1)) == VW'(k));
                        end
                        wl_we      = 1'b1;
                        head_next  = '0;
                        tail_next  = CW'(1);
                        bad_next   = 1'b0;
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP: begin
                if (mode_reg == gte_pkg::MODE_BFS) begin
                    head_next = head_reg + CW'(1);
                end else begin
                    tail_next = tail_reg - CW'(1);
                end
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                cur_next   = wl_rd_reg;
                state_next = ST_ROW;
            end
            ST_ROW: begin
                cand_next  = adj_row & n_mask & ~vis_map;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (pick.found) begin
                    cand_next = cand_reg & ~pick.onehot;
                    if (tail_reg < CW'(MAX_VERTICES)) begin
                        wl_we    = 1'b1;
                        wl_waddr = tail_reg[AW-1:0];
                        wl_wdata = VW'(pick.idx) + VW'(1);
                        tail_next = tail_reg + CW'(1);
                        for (int k = 0; k < MapW; k++) begin
                            vis_next[k] = vis_reg[k] | pick.onehot[k];
                        end
                    end
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    out_valid_next  = 1'b1;
                    out_vertex_next = cur_reg;
                    out_last_next   = bad_reg || list_empty;
                    out_bad_next    = bad_reg;
                    state_next      = (bad_reg || list_empty) ? ST_IDLE : ST_POP;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            vis_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            vis_reg       <= vis_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        cand_reg       <= cand_next;
        out_vertex_reg <= out_vertex_next;
        out_last_reg   <= out_last_next;
        out_bad_reg    <= out_bad_next;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= gte_pkg::MODE_BFS;
            count_reg <= gte_pkg::COUNT_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_addr == gte_pkg::REG_MODE) begin
                mode_reg <= cfg_wdata[0];
            end
            if (cfg_addr == gte_pkg::REG_COUNT) begin
                count_reg <= cfg_wdata[VW-1:0];
            end
        end
    end

    // Result stream outputs.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(gte_pkg::M_DATA_W - VW){1'b0}}, out_vertex_reg};
    assign m_tuser  = out_bad_reg;
    assign m_tlast  = out_last_reg;

    // The read pointer never passes the write pointer.
    `GTE_ASSERT_NOW(a_head_le_tail, aclk, aresetn, state_reg != ST_IDLE, head_reg <= tail_reg)
    // The list never holds more entries than it has room for.
    `GTE_ASSERT_NOW(a_tail_bound, aclk, aresetn, 1'b1, tail_reg <= CW'(MAX_VERTICES))
    // A picked neighbor was never marked before it is pushed.
    `GTE_ASSERT_NOW(a_push_unvisited, aclk, aresetn, state_reg == ST_SCAN && pick.found, (vis_map & pick.onehot) == '0)
    // An error result is always the final one of its transaction group.
    `GTE_ASSERT_NOW(a_bad_is_last, aclk, aresetn, out_valid_reg && out_bad_reg, out_last_reg && out_vertex_reg == '0)
    // A normal result names a vertex inside the store.
    `GTE_ASSERT_NOW(a_vertex_range, aclk, aresetn, out_valid_reg && !out_bad_reg, out_vertex_reg != '0 && (VW+1)'(out_vertex_reg) <= (VW+1)'(MAX_VERTICES))

endmodule
